>>> design/sparse_linear_poly2_classifier_unit_assert.svh
// Assertion macros used by the classifier unit.
`ifndef SPARSE_LINEAR_POLY2_CLASSIFIER_UNIT_ASSERT_SVH
`define SPARSE_LINEAR_POLY2_CLASSIFIER_UNIT_ASSERT_SVH
// Same-cycle implication, masked during reset.
`define SLP2C_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, masked during reset.
`define SLP2C_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> design/slp2c_pkg.sv
// ----------------------------------------------------------------------------
// slp2c_pkg
// Shared types, constants and helpers of the sparse poly2 classifier.
// ----------------------------------------------------------------------------
package slp2c_pkg;

  localparam int ACC_W     = 48;
  localparam int Q_W       = 32;
  localparam int FRAC_W    = 24;
  localparam int IDX_W     = 12;
  localparam int WADDR_W   = 14;
  localparam int CLS_W     = 3;
  localparam int CFG_IDX_W = 4;
  localparam int ROW_W     = 26;

  localparam int DEF_WEIGHT_DEPTH = 16384;
  localparam int DEF_MAX_NONZERO  = 64;
  localparam int DEF_MAX_CLASSES  = 8;

  localparam logic signed [ACC_W-1:0] SAT_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_NUM_FEATURES = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CLASSES  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_COLS  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POLY_MODE    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF0        = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA        = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_S2_GAMMA     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_S2_COEF0_G   = 4'd7;

  localparam logic REQ_WEIGHT = 1'b0;

  typedef enum logic [4:0] {
    S_IDLE, S_L_ADDR, S_L_MUL, S_L_WAIT,
    S_P_CLR, S_P0_ADDR, S_P0_MUL, S_P0_WAIT,
    S_K_RD, S_K_LAT, S_C_START,
    S_J_RD, S_J_LAT, S_J_MUL, S_J_WAIT,
    S_T1_MUL, S_T1_WAIT,
    S_W2_ADDR, S_W2_MUL, S_W2_WAIT, S_W2B_MUL, S_W2B_WAIT,
    S_W3_ADDR, S_W3_MUL, S_W3_WAIT,
    S_ACC_MUL, S_ACC_WAIT,
    S_DEC, S_DEC_LOOP, S_OUT
  } state_t;

  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] a;
    logic signed [Q_W-1:0]   b;
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] res;
  } mul_rsp_t;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] x,
    input logic signed [ACC_W-1:0] y
  );
    logic signed [ACC_W:0] s;
    s = {x[ACC_W-1], x} + {y[ACC_W-1], y};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? SAT_MIN : SAT_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

>>> design/sparse_linear_poly2_classifier_unit.sv
// ----------------------------------------------------------------------------
// sparse_linear_poly2_classifier_unit
// Sparse linear / degree-2 polynomial classifier built around one shared
// four-stage multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Weight word: written to the weight RAM when accepted. Feature word, linear mode:
//   per weight column an address step, a multiplier start and 4 multiplier stages.
// Polynomial mode buffers kept words; the last word runs the bias terms per column,
//   then per kept k a buffer read, and per column a product per later j plus fixed terms.
// Decision: sign of class 0 when binary, else argmax over num_classes; then load result.
// Input is not ready while a word is in flight; result sits in an output
//   register. Sync reset clears control, config and accumulators.
// ----------------------------------------------------------------------------
module sparse_linear_poly2_classifier_unit
  import slp2c_pkg::*;
#(
  parameter int WEIGHT_DEPTH = DEF_WEIGHT_DEPTH, // power of two
  parameter int MAX_NONZERO  = DEF_MAX_NONZERO,
  parameter int MAX_CLASSES  = DEF_MAX_CLASSES
) (
  input  logic                    clk,
  input  logic                    rst,
  // input words
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    req_type,
  input  logic [WADDR_W-1:0]      weight_addr,
  input  logic signed [Q_W-1:0]   weight_word,
  input  logic [IDX_W-1:0]        feature_index,
  input  logic signed [Q_W-1:0]   feature_value,
  input  logic                    last,
  // result words
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CLS_W-1:0]        class_index,
  output logic signed [ACC_W-1:0] decision_value,
  // config writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]             cfg_data
);

`include "sparse_linear_poly2_classifier_unit_assert.svh"

  localparam int AW   = $clog2(WEIGHT_DEPTH);
  localparam int BAW  = $clog2(MAX_NONZERO);
  localparam int BCW  = $clog2(MAX_NONZERO + 1);
  localparam int NW   = $clog2(MAX_CLASSES + 1);
  localparam int CIW  = $clog2(MAX_CLASSES);
  localparam int BUFW = IDX_W + Q_W;

  // config registers
  logic [IDX_W-1:0]      cfg_nf;
  logic [3:0]            cfg_ncls;
  logic [3:0]            cfg_wcol;
  logic                  cfg_poly;
  logic signed [Q_W-1:0] cfg_coef0, cfg_gamma, cfg_s2g, cfg_s2cg;

  state_t state, state_next;

  logic signed [ACC_W-1:0] acc [MAX_CLASSES];
  logic [BCW-1:0] count, k, j;
  logic [NW-1:0]  c;
  logic [CIW-1:0] ci;

  // latched word and working registers
  logic [IDX_W-1:0]        idx_reg, ik;
  logic signed [Q_W-1:0]   val_reg, vk, vj;
  logic                    last_reg;
  logic [ROW_W-1:0]        base;
  logic signed [ACC_W-1:0] t, tmp, bestv;
  logic [CIW-1:0]          best;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  logic in_acc, is_feat, kept, out_free;
  logic [NW-1:0] ncol, ncls;
  logic binary, col_last, cls_last, more_k, more_j;

  // weight RAM
  logic [AW-1:0]  w_waddr, w_raddr;
  logic [Q_W-1:0] w_rdata;
  logic signed [ACC_W-1:0] w_ext;
  logic [31:0]    wa_ext, addr_full;
  logic [ROW_W-1:0] row;

  // feature buffer RAM {index, value}
  logic           b_we;
  logic [BAW-1:0] b_raddr;
  logic [BUFW-1:0] b_rdata;
  logic [IDX_W-1:0] rd_idx;
  logic signed [Q_W-1:0] rd_val;
  logic [13:0]      tri_span;
  logic [ROW_W-1:0] tri_prod;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign is_feat   = (req_type != REQ_WEIGHT);
  assign kept      = (feature_index != '0) && (feature_index <= cfg_nf);
  assign out_free  = !out_valid || out_ready;

  // effective column / class counts
  always_comb begin
    if (cfg_wcol == '0) begin
      ncol = NW'(1);
    end else if (32'(cfg_wcol) > MAX_CLASSES) begin
      ncol = NW'(MAX_CLASSES);
    end else begin
      ncol = NW'(cfg_wcol);
    end
    if (32'(cfg_ncls) > MAX_CLASSES) begin
      ncls = NW'(MAX_CLASSES);
    end else begin
      ncls = NW'(cfg_ncls);
    end
  end

  assign binary   = (cfg_ncls <= 4'd2) || (MAX_CLASSES <= 2);
  assign ci       = c[CIW-1:0];
  assign col_last = (NW'(c + NW'(1)) == ncol);
  assign cls_last = (NW'(c + NW'(1)) == ncls);
  assign more_k   = (BCW'(k + BCW'(1)) < count);
  assign more_j   = (BCW'(j + BCW'(1)) < count);

  assign rd_idx   = b_rdata[BUFW-1:Q_W];
  assign rd_val   = b_rdata[Q_W-1:0];
  assign w_ext    = {{(ACC_W-Q_W){w_rdata[Q_W-1]}}, w_rdata};

  // triangular base: ik*(2n-ik+1)/2
  assign tri_span = 14'({cfg_nf, 1'b1}) - 14'(rd_idx);
  assign tri_prod = ROW_W'(rd_idx) * ROW_W'(tri_span);

  // weight address: (row*C + c) mod depth
  always_comb begin
    case (state)
      S_L_ADDR:  row = ROW_W'(idx_reg) - ROW_W'(1);
      S_J_LAT:   row = base + ROW_W'(rd_idx);
      S_W2_ADDR: row = base + ROW_W'(ik);
      S_W3_ADDR: row = ROW_W'(ik);
      default:   row = '0;
    endcase
    addr_full = 32'(32'(row) * 32'(ncol)) + 32'(c);
    w_raddr   = addr_full[AW-1:0];
    wa_ext    = 32'(weight_addr);
    w_waddr   = wa_ext[AW-1:0];
  end

  slp2c_ram #(.WIDTH(Q_W), .DEPTH(WEIGHT_DEPTH)) u_wram (
    .clk   (clk),
    .we    (in_acc && !is_feat),
    .waddr (w_waddr),
    .wdata (weight_word),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  assign b_we = in_acc && is_feat && kept && cfg_poly && (count < BCW'(MAX_NONZERO));

  slp2c_ram #(.WIDTH(BUFW), .DEPTH(MAX_NONZERO)) u_bram (
    .clk   (clk),
    .we    (b_we),
    .waddr (count[BAW-1:0]),
    .wdata ({feature_index, feature_value}),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  slp2c_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  // multiplier operand select and buffer read address
  always_comb begin
    mreq.start = 1'b0;
    mreq.a     = w_ext;
    mreq.b     = val_reg;
    b_raddr    = (state == S_J_RD) ? j[BAW-1:0] : k[BAW-1:0];
    case (state)
      S_L_MUL:   begin mreq.start = 1'b1; mreq.b = val_reg;   end
      S_P0_MUL:  begin mreq.start = 1'b1; mreq.b = cfg_coef0; end
      S_J_MUL:   begin mreq.start = 1'b1; mreq.b = vj;        end
      S_T1_MUL:  begin mreq.start = 1'b1; mreq.a = t;   mreq.b = cfg_s2g;   end
      S_W2_MUL:  begin mreq.start = 1'b1; mreq.b = vk;        end
      S_W2B_MUL: begin mreq.start = 1'b1; mreq.a = tmp; mreq.b = cfg_gamma; end
      S_W3_MUL:  begin mreq.start = 1'b1; mreq.b = cfg_s2cg;  end
      S_ACC_MUL: begin mreq.start = 1'b1; mreq.a = t;   mreq.b = vk;        end
      default:   mreq.start = 1'b0;
    endcase
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc && is_feat) begin
          if (kept && !cfg_poly) begin
            state_next = S_L_ADDR;
          end else if (last) begin
            state_next = cfg_poly ? S_P_CLR : S_DEC;
          end
        end
      end
      S_L_ADDR: state_next = S_L_MUL;
      S_L_MUL:  state_next = S_L_WAIT;
      S_L_WAIT: begin
        if (mrsp.done) begin
          if (!col_last) begin
            state_next = S_L_ADDR;
          end else begin
            state_next = last_reg ? S_DEC : S_IDLE;
          end
        end
      end
      S_P_CLR:   state_next = S_P0_ADDR;
      S_P0_ADDR: state_next = S_P0_MUL;
      S_P0_MUL:  state_next = S_P0_WAIT;
      S_P0_WAIT: begin
        if (mrsp.done) begin
          if (!col_last) begin
            state_next = S_P0_ADDR;
          end else begin
            state_next = (count == '0) ? S_DEC : S_K_RD;
          end
        end
      end
      S_K_RD:    state_next = S_K_LAT;
      S_K_LAT:   state_next = S_C_START;
      S_C_START: state_next = more_k ? S_J_RD : S_T1_MUL;
      S_J_RD:    state_next = S_J_LAT;
      S_J_LAT:   state_next = S_J_MUL;
      S_J_MUL:   state_next = S_J_WAIT;
      S_J_WAIT:  if (mrsp.done) state_next = more_j ? S_J_RD : S_T1_MUL;
      S_T1_MUL:  state_next = S_T1_WAIT;
      S_T1_WAIT: if (mrsp.done) state_next = S_W2_ADDR;
      S_W2_ADDR: state_next = S_W2_MUL;
      S_W2_MUL:  state_next = S_W2_WAIT;
      S_W2_WAIT: if (mrsp.done) state_next = S_W2B_MUL;
      S_W2B_MUL: state_next = S_W2B_WAIT;
      S_W2B_WAIT: if (mrsp.done) state_next = S_W3_ADDR;
      S_W3_ADDR: state_next = S_W3_MUL;
      S_W3_MUL:  state_next = S_W3_WAIT;
      S_W3_WAIT: if (mrsp.done) state_next = S_ACC_MUL;
      S_ACC_MUL: state_next = S_ACC_WAIT;
      S_ACC_WAIT: begin
        if (mrsp.done) begin
          if (!col_last) begin
            state_next = S_C_START;
          end else begin
            state_next = more_k ? S_K_RD : S_DEC;
          end
        end
      end
      S_DEC:      state_next = binary ? S_OUT : S_DEC_LOOP;
      S_DEC_LOOP: if (cls_last) state_next = S_OUT;
      S_OUT:      if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // control registers, config and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      k         <= '0;
      j         <= '0;
      c         <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_CLASSES; i++) acc[i] <= '0;
      cfg_nf    <= IDX_W'(1);
      cfg_ncls  <= 4'd2;
      cfg_wcol  <= 4'd1;
      cfg_poly  <= 1'b0;
      cfg_coef0 <= '0;
      cfg_gamma <= '0;
      cfg_s2g   <= '0;
      cfg_s2cg  <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NUM_FEATURES: cfg_nf    <= cfg_data[IDX_W-1:0];
          REG_NUM_CLASSES:  cfg_ncls  <= cfg_data[3:0];
          REG_WEIGHT_COLS:  cfg_wcol  <= cfg_data[3:0];
          REG_POLY_MODE:    cfg_poly  <= cfg_data[0];
          REG_COEF0:        cfg_coef0 <= cfg_data;
          REG_GAMMA:        cfg_gamma <= cfg_data;
          REG_S2_GAMMA:     cfg_s2g   <= cfg_data;
          REG_S2_COEF0_G:   cfg_s2cg  <= cfg_data;
          default: ;
        endcase
      end
      // load a new result, or drop the old one once taken
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          c <= '0;
          if (b_we) count <= BCW'(count + BCW'(1));
        end
        S_L_WAIT, S_P0_WAIT: begin
          if (mrsp.done) begin
            acc[ci] <= sat_add(acc[ci], mrsp.res);
            c       <= col_last ? '0 : NW'(c + NW'(1));
            k       <= '0;
          end
        end
        S_P_CLR: begin
          for (int i = 0; i < MAX_CLASSES; i++) acc[i] <= '0;
          c <= '0;
        end
        S_K_LAT:   c <= '0;
        S_C_START: j <= BCW'(k + BCW'(1));
        S_J_WAIT:  if (mrsp.done) j <= BCW'(j + BCW'(1));
        S_ACC_WAIT: begin
          if (mrsp.done) begin
            acc[ci] <= sat_add(acc[ci], mrsp.res);
            c       <= col_last ? '0 : NW'(c + NW'(1));
            if (col_last) k <= BCW'(k + BCW'(1));
          end
        end
        S_DEC:      c <= NW'(1);
        S_DEC_LOOP: c <= NW'(c + NW'(1));
        S_OUT: begin
          if (out_free) begin
            count     <= '0;
            for (int i = 0; i < MAX_CLASSES; i++) acc[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          idx_reg  <= feature_index;
          val_reg  <= feature_value;
          last_reg <= last;
        end
      end
      S_K_LAT: begin
        ik   <= rd_idx;
        vk   <= rd_val;
        base <= tri_prod >> 1;
      end
      S_C_START:  t <= '0;
      S_J_LAT:    vj <= rd_val;
      S_J_WAIT:   if (mrsp.done) t <= sat_add(t, mrsp.res);
      S_T1_WAIT:  if (mrsp.done) t <= mrsp.res;
      S_W2_WAIT:  if (mrsp.done) tmp <= mrsp.res;
      S_W2B_WAIT: if (mrsp.done) t <= sat_add(t, mrsp.res);
      S_W3_WAIT:  if (mrsp.done) t <= sat_add(t, mrsp.res);
      S_DEC: begin
        bestv <= acc[0];
        best  <= '0;
      end
      S_DEC_LOOP: begin
        // strict compare keeps the first maximum
        if (acc[ci] > bestv) begin
          bestv <= acc[ci];
          best  <= ci;
        end
      end
      S_OUT: begin
        if (out_free) begin
          decision_value <= bestv;
          if (binary) begin
            class_index <= (bestv > 0) ? CLS_W'(0) : CLS_W'(1);
          end else begin
            class_index <= CLS_W'(best);
          end
        end
      end
      default: ;
    endcase
  end

  `SLP2C_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= BCW'(MAX_NONZERO), "buffer count overrun")
  `SLP2C_ASSERT_NOW(a_col_range, clk, rst, state == S_L_ADDR || state == S_P0_ADDR, c < ncol, "column past weight_columns")
  `SLP2C_ASSERT_NOW(a_done_waiting, clk, rst, mrsp.done, state == S_L_WAIT || state == S_P0_WAIT || state == S_J_WAIT || state == S_T1_WAIT || state == S_W2_WAIT || state == S_W2B_WAIT || state == S_W3_WAIT || state == S_ACC_WAIT, "multiplier result with no waiter")
  `SLP2C_ASSERT_NEXT(a_out_load, clk, rst, state == S_OUT && out_free, out_valid && count == '0 && state == S_IDLE, "result not loaded")

endmodule

>>> design/slp2c_ram.sv
// ----------------------------------------------------------------------------
// slp2c_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slp2c_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/slp2c_mul.sv
// ----------------------------------------------------------------------------
// slp2c_mul
// Shared Q-format multiplier: 48b x 32b, >>24 toward zero, 48b saturate.
// ----------------------------------------------------------------------------
module slp2c_mul
  import slp2c_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int M_W  = 56;
  localparam int HI_W = ACC_W - FRAC_W;
  localparam logic [M_W-1:0] NEG_LIM = M_W'(1) << (ACC_W - 1);
  localparam logic [M_W-1:0] POS_LIM = NEG_LIM - M_W'(1);

  logic [3:0] vld;

  logic             neg1, neg2, neg3;
  logic [ACC_W-1:0] ua1;
  logic [Q_W-1:0]   ub1, ub2;
  logic [HI_W-1:0]  uahi2;
  logic [M_W-1:0]   plo2, m3;
  logic signed [ACC_W-1:0] res4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], req.start};
    end
  end

  // stage 1: sign/magnitude split; stage 2: low partial; stage 3: high partial
  always_ff @(posedge clk) begin
    neg1  <= req.a[ACC_W-1] ^ req.b[Q_W-1];
    ua1   <= req.a[ACC_W-1] ? ACC_W'(-req.a) : ACC_W'(req.a);
    ub1   <= req.b[Q_W-1] ? Q_W'(-req.b) : Q_W'(req.b);
    plo2  <= M_W'(ua1[FRAC_W-1:0]) * M_W'(ub1);
    uahi2 <= ua1[ACC_W-1:FRAC_W];
    ub2   <= ub1;
    neg2  <= neg1;
    m3    <= M_W'(uahi2) * M_W'(ub2) + (plo2 >> FRAC_W);
    neg3  <= neg2;
    if (neg3) begin
      res4 <= (m3 > NEG_LIM) ? SAT_MIN : ACC_W'(-m3);
    end else begin
      res4 <= (m3 > POS_LIM) ? SAT_MAX : ACC_W'(m3);
    end
  end

  assign rsp.done = vld[3];
  assign rsp.res  = res4;

endmodule
